// ----- rtl/msmix_pkg.sv -----
// ----------------------------------------------------------------------------
// msmix_pkg
// Shared types and constants of the multichannel sample mixer.
// ----------------------------------------------------------------------------
package msmix_pkg;

   localparam int NUM_VOICES       = 16;
   localparam int SAMPLE_ADDR_BITS = 16;

   localparam int VOICE_BITS = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int MEM_WORDS  = 1 << SAMPLE_ADDR_BITS;
   localparam int MASK_BITS  = (NUM_VOICES < 16) ? NUM_VOICES : 16;

   localparam int SAMPLE_BITS = 16;
   localparam int POS_BITS    = 25;
   localparam int FRAC_BITS   = 8;
   localparam int STEP_BITS   = 12;
   localparam int VOL_BITS    = 8;
   localparam int LOOP_BITS   = 8;
   localparam int ACC_BITS    = SAMPLE_BITS + VOICE_BITS + 1;

   localparam logic [VOL_BITS-1:0] UNITY_LIMIT = 8'd250;

   localparam logic signed [ACC_BITS-1:0] SAT_MIN = ACC_BITS'(-32768);
   localparam logic signed [ACC_BITS-1:0] SAT_MAX = ACC_BITS'(32'sh7fff);
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = 16'h8000;
   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = 16'h7fff;

   localparam int REQ_DATA_BITS = 88;
   localparam int RSP_DATA_BITS = 32;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_START  = 3'd2,
      OP_STOP   = 3'd3,
      OP_RETUNE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MIX   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

// ----- rtl/multichannel_sample_mixer_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_sample_mixer_top
// PCM playback mixer: sample memory, per-voice playback state and a shared
// read / multiply / accumulate pipeline stepped over the voices.
// ----------------------------------------------------------------------------
// Write, start, stop and retune transfers are accepted whenever the sequencer
// is idle. A tick transfer starts the sequencer, which walks the voices one
// per cycle through the single sample memory read port and the shared
// multiplier and accumulator, then the pipeline drains and the saturated sum
// is loaded into the output register once it is free. req_tready is low while
// a tick is in progress, and a finished sum waits in the output register.
module multichannel_sample_mixer_top
   import msmix_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // channel[3:0], address[19:4], sample_value[35:20], length[52:36],
   // loop_count[60:53], step[72:61], volume[80:73], zero fill[87:81]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // op[2:0]
   input  logic [2:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // mixed_sample[15:0], active_mask[31:16]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // clipped[0]
   output logic                     rsp_tuser
);

   logic [3:0]                   in_channel;
   logic [15:0]                  in_address;
   logic [SAMPLE_BITS-1:0]       in_sample;
   logic [16:0]                  in_length;
   logic [LOOP_BITS-1:0]         in_loops;
   logic [STEP_BITS-1:0]         in_step;
   logic [VOL_BITS-1:0]          in_volume;
   op_type                       in_op;

   state_type                    state_ff, state_in;
   logic [VOICE_BITS-1:0]        voice_ff, voice_in;
   logic                         req_fire;
   logic                         cmd_fire;
   logic                         ch_ok;
   logic [VOICE_BITS-1:0]        ch_idx;
   logic                         mix_issue;
   logic                         voice_live;

   logic [NUM_VOICES-1:0]        active_ff;
   logic [SAMPLE_ADDR_BITS-1:0]  base_ff   [NUM_VOICES];
   logic [POS_BITS-1:0]          length_ff [NUM_VOICES];
   logic [POS_BITS-1:0]          pos_ff    [NUM_VOICES];
   logic [STEP_BITS-1:0]         step_ff   [NUM_VOICES];
   logic [VOL_BITS-1:0]          vol_ff    [NUM_VOICES];
   logic [LOOP_BITS-1:0]         loops_ff  [NUM_VOICES];

   logic [POS_BITS-1:0]          pos_sum;
   logic                         pos_wrap;
   logic [POS_BITS-1:0]          pos_new;

   logic [SAMPLE_BITS-1:0]       sample_mem [MEM_WORDS];
   logic [SAMPLE_ADDR_BITS-1:0]  mem_addr;
   logic                         mem_we;
   logic [SAMPLE_BITS-1:0]       mem_rdata_ff;

   logic                         s1_valid_ff;
   logic [VOL_BITS-1:0]          vol_s1_ff;
   logic                         unity_s1_ff;
   logic signed [24:0]           product;
   logic                         s2_valid_ff;
   logic signed [SAMPLE_BITS-1:0] contrib_ff;
   logic signed [ACC_BITS-1:0]   acc_ff;

   logic                         pipe_empty;
   logic                         out_free;
   logic                         out_load;
   logic [SAMPLE_BITS-1:0]       sat_sample;
   logic                         sat_clip;

   logic                         rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]       rsp_sample_ff;
   logic                         rsp_clip_ff;
   logic [15:0]                  rsp_mask_ff;

   assign in_op      = op_type'(req_tuser);
   assign in_channel = req_tdata[3:0];
   assign in_address = req_tdata[19:4];
   assign in_sample  = req_tdata[35:20];
   assign in_length  = req_tdata[52:36];
   assign in_loops   = req_tdata[60:53];
   assign in_step    = req_tdata[72:61];
   assign in_volume  = req_tdata[80:73];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign ch_ok      = ({28'd0, in_channel} < 32'(NUM_VOICES));
   assign ch_idx     = VOICE_BITS'(in_channel);
   assign cmd_fire   = req_fire && ch_ok;
   assign mix_issue  = (state_ff == ST_MIX);
   assign voice_live = active_ff[voice_ff];

   assign pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_DRAIN) && pipe_empty && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      voice_in = voice_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && in_op == OP_TICK) begin
               state_in = ST_MIX;
               voice_in = '0;
            end
         end
         ST_MIX: begin
            if (voice_ff == VOICE_BITS'(NUM_VOICES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               voice_in = voice_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         voice_ff <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
      end
   end

   // position advance for the voice being issued
   assign pos_sum  = pos_ff[voice_ff] + POS_BITS'(step_ff[voice_ff]);
   assign pos_wrap = (pos_sum >= length_ff[voice_ff]);
   assign pos_new  = pos_wrap ? (pos_sum - length_ff[voice_ff]) : pos_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            base_ff[i]   <= '0;
            length_ff[i] <= '0;
            pos_ff[i]    <= '0;
            step_ff[i]   <= '0;
            vol_ff[i]    <= '0;
            loops_ff[i]  <= '0;
         end
      end else if (cmd_fire) begin
         case (in_op)
            OP_START: begin
               base_ff[ch_idx]   <= SAMPLE_ADDR_BITS'(in_address);
               length_ff[ch_idx] <= {in_length, 8'h00};
               pos_ff[ch_idx]    <= '0;
               step_ff[ch_idx]   <= in_step;
               vol_ff[ch_idx]    <= in_volume;
               loops_ff[ch_idx]  <= in_loops;
               active_ff[ch_idx] <= 1'b1;
            end
            OP_STOP: begin
               active_ff[ch_idx] <= 1'b0;
            end
            OP_RETUNE: begin
               step_ff[ch_idx]   <= in_step;
               vol_ff[ch_idx]    <= in_volume;
               loops_ff[ch_idx]  <= in_loops;
            end
            default: begin
            end
         endcase
      end else if (mix_issue && voice_live) begin
         pos_ff[voice_ff] <= pos_new;
         if (pos_wrap) begin
            if (loops_ff[voice_ff] == '0) begin
               active_ff[voice_ff] <= 1'b0;
            end else begin
               loops_ff[voice_ff] <= loops_ff[voice_ff] - 1'b1;
            end
         end
      end
   end

   // sample memory, single port
   assign mem_we   = req_fire && (in_op == OP_WRITE);
   assign mem_addr = mix_issue
                   ? base_ff[voice_ff]
                     + SAMPLE_ADDR_BITS'(pos_ff[voice_ff][POS_BITS-1:FRAC_BITS])
                   : SAMPLE_ADDR_BITS'(in_address);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_addr] <= in_sample;
      end
      mem_rdata_ff <= sample_mem[mem_addr];
   end

   // shared multiply and accumulate
   assign product = $signed(mem_rdata_ff) * $signed({1'b0, vol_s1_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= mix_issue && voice_live;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      vol_s1_ff   <= vol_ff[voice_ff];
      unity_s1_ff <= (vol_ff[voice_ff] > UNITY_LIMIT);
      contrib_ff  <= unity_s1_ff ? $signed(mem_rdata_ff) : product[23:8];
   end

   always_ff @(posedge clock) begin
      if (req_fire && in_op == OP_TICK) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + ACC_BITS'(contrib_ff);
      end
   end

   // saturate and hold the result
   always_comb begin
      sat_clip   = 1'b0;
      sat_sample = acc_ff[SAMPLE_BITS-1:0];
      if (acc_ff < SAT_MIN) begin
         sat_clip   = 1'b1;
         sat_sample = OUT_MIN;
      end else if (acc_ff > SAT_MAX) begin
         sat_clip   = 1'b1;
         sat_sample = OUT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= sat_sample;
         rsp_clip_ff   <= sat_clip;
         rsp_mask_ff   <= 16'(active_ff[MASK_BITS-1:0]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mask_ff, rsp_sample_ff};
   assign rsp_tuser  = rsp_clip_ff;

`ifndef SYNTHESIS
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("mix pipeline busy while idle");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("accumulate stage without a read stage");

   a_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clip_ff) |->
         (rsp_sample_ff == OUT_MIN || rsp_sample_ff == OUT_MAX))
      else $error("clipped result not at a rail");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel sample mixer. Commands go in on
// the request stream, mixed ticks come back on the result stream. A voice
// model runs on every accepted request and queues the mix each tick should
// produce; results are compared field by field in order. A short directed
// table covers reset, saturation, the unity limit, idle retune, zero-length
// voices and reserved ops. A random run of voice traffic with some reserved
// ops follows, with random gaps on both sides and one long receiver hold-off.
// Sample words are always written before any voice can read them.
// ----------------------------------------------------------------------------
module tb
   import msmix_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

   localparam int IDLE_PCT       = 11;
   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 800;
   localparam int QUIET_FIRST    = 400;
   localparam int QUIET_LAST     = 550;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  chan;
      logic [15:0] addr;
      logic [15:0] value;
      logic [16:0] len;
      logic [7:0]  loops;
      logic [11:0] step;
      logic [7:0]  vol;
   } mixer_cmd_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        clip;
      logic [15:0] mask;
   } mix_result_type;

   typedef struct packed {
      mixer_cmd_type  cmd;
      logic           typed;
      mix_result_type result;
   } table_row_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [2:0]               req_tuser  = '0;
   logic                     rsp_tready = 1'b0;
   wire                      req_tready;
   wire                      rsp_tvalid;
   wire  [RSP_DATA_BITS-1:0] rsp_tdata;
   wire                      rsp_tuser;

   multichannel_sample_mixer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // voice model state
   bit [15:0] sample_mem   [MEM_WORDS];
   bit        mem_written  [MEM_WORDS];
   bit        v_active     [NUM_VOICES];
   bit [15:0] v_base       [NUM_VOICES];
   bit [24:0] v_len        [NUM_VOICES];
   bit [24:0] v_pos        [NUM_VOICES];
   bit [11:0] v_step       [NUM_VOICES];
   bit [7:0]  v_vol        [NUM_VOICES];
   bit [7:0]  v_loops      [NUM_VOICES];

   mix_result_type pending_mixes[$];
   table_row_type  dir_rows[$];

   logic           row_typed  = 1'b0;
   mix_result_type row_result = '0;
   int             fail_count = 0;
   int             stall_cycles = 0;
   int             items_driven = 0;
   bit             quiet = 1'b0;
   bit             holdoff_req = 1'b0;
   int             holdoff_left = 0;

   function automatic mix_result_type mix_voices();
      int             sum;
      int             s;
      int             c;
      logic [15:0]    a;
      logic [24:0]    p;
      mix_result_type r;
      sum = 0;
      r = '0;
      for (int n = 0; n < NUM_VOICES; n++) begin
         if (v_active[n]) begin
            a = 16'(v_base[n] + v_pos[n][POS_BITS-1:FRAC_BITS]);
            s = $signed(sample_mem[a]);
            c = (v_vol[n] > UNITY_LIMIT) ? s : (s * int'(v_vol[n])) >>> 8;
            sum += c;
            p = v_pos[n] + 25'(v_step[n]);
            if (p >= v_len[n]) begin
               p -= v_len[n];
               if (v_loops[n] == 8'd0) v_active[n] = 1'b0;
               else v_loops[n] = v_loops[n] - 8'd1;
            end
            v_pos[n] = p;
         end
      end
      if (sum < -32768) begin
         sum = -32768;
         r.clip = 1'b1;
      end else if (sum > 32767) begin
         sum = 32767;
         r.clip = 1'b1;
      end
      r.sample = sum[15:0];
      for (int n = 0; n < MASK_BITS; n++) r.mask[n] = v_active[n];
      return r;
   endfunction

   function automatic void apply_voice_cmd(mixer_cmd_type c);
      case (c.op)
         OP_WRITE: begin
            sample_mem[c.addr] = c.value;
            mem_written[c.addr] = 1'b1;
         end
         OP_START: begin
            if (c.chan < NUM_VOICES) begin
               v_base[c.chan]   = c.addr;
               v_len[c.chan]    = {c.len, 8'd0};
               v_pos[c.chan]    = '0;
               v_step[c.chan]   = c.step;
               v_vol[c.chan]    = c.vol;
               v_loops[c.chan]  = c.loops;
               v_active[c.chan] = 1'b1;
            end
         end
         OP_STOP: begin
            if (c.chan < NUM_VOICES) v_active[c.chan] = 1'b0;
         end
         OP_RETUNE: begin
            if (c.chan < NUM_VOICES) begin
               v_step[c.chan]  = c.step;
               v_vol[c.chan]   = c.vol;
               v_loops[c.chan] = c.loops;
            end
         end
         default: ;
      endcase
   endfunction

   // {found, address} of a word the next tick would read before it is written
   function automatic logic [16:0] next_unfilled();
      logic [15:0] a;
      for (int n = 0; n < NUM_VOICES; n++) begin
         if (v_active[n]) begin
            a = 16'(v_base[n] + v_pos[n][POS_BITS-1:FRAC_BITS]);
            if (!mem_written[a]) return {1'b1, a};
         end
      end
      return '0;
   endfunction

   function automatic logic [15:0] pick_sample();
      if ($urandom_range(99) < 15) return $urandom_range(1) ? OUT_MAX : OUT_MIN;
      return 16'($urandom);
   endfunction

   function automatic mixer_cmd_type random_fields();
      mixer_cmd_type c;
      c.op    = OP_TICK;
      c.chan  = 4'($urandom);
      c.addr  = 16'($urandom);
      c.value = 16'($urandom);
      c.len   = 17'($urandom);
      c.loops = 8'($urandom);
      c.step  = 12'($urandom);
      c.vol   = 8'($urandom);
      return c;
   endfunction

   function automatic void shape_tuning(inout mixer_cmd_type c);
      int r;
      r = $urandom_range(9);
      if (r < 7) c.loops = 8'($urandom_range(3));
      else if (r == 7) c.loops = 8'hff;
      if ($urandom_range(9) < 6) c.step = 12'($urandom_range(511));
      if ($urandom_range(9) < 2) begin
         case ($urandom_range(3))
            0: c.vol = 8'd0;
            1: c.vol = UNITY_LIMIT;
            2: c.vol = UNITY_LIMIT + 8'd1;
            default: c.vol = 8'hff;
         endcase
      end
   endfunction

   task automatic add_cmd(input logic [2:0] op, input logic [3:0] chan,
                          input logic [15:0] addr, input logic [15:0] value,
                          input logic [16:0] len, input logic [7:0] loops,
                          input logic [11:0] step, input logic [7:0] vol);
      table_row_type row;
      row.cmd    = {op, chan, addr, value, len, loops, step, vol};
      row.typed  = 1'b0;
      row.result = '0;
      dir_rows.push_back(row);
   endtask

   task automatic add_checked(input logic [15:0] sample, input logic clip,
                              input logic [15:0] mask);
      table_row_type row;
      row.cmd    = '0;
      row.cmd.op = OP_TICK;
      row.typed  = 1'b1;
      row.result = {sample, clip, mask};
      dir_rows.push_back(row);
   endtask

   task automatic drive_one(input mixer_cmd_type c, input logic typed,
                            input mix_result_type res);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {7'd0, c.vol, c.step, c.loops, c.len, c.value, c.addr, c.chan};
      row_typed  <= typed;
      row_result <= res;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_driven++;
      @(negedge clock);
   endtask

   task automatic issue(input mixer_cmd_type c, input logic typed,
                        input mix_result_type res);
      logic [16:0]   hole;
      mixer_cmd_type fill;
      if (c.op == OP_TICK) begin
         hole = next_unfilled();
         while (hole[16]) begin
            fill = random_fields();
            fill.op = OP_WRITE;
            fill.addr = hole[15:0];
            fill.value = pick_sample();
            drive_one(fill, 1'b0, '0);
            hole = next_unfilled();
         end
      end
      drive_one(c, typed, res);
   endtask

   // result side
   initial begin
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            holdoff_left = HOLD_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      mix_result_type got;
      mix_result_type want;
      mixer_cmd_type  cmd;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tuser, rsp_tdata[31:16]};
            if (pending_mixes.size() == 0) begin
               $error("result transfer with no mix pending: %h", got);
               fail_count++;
            end else begin
               want = pending_mixes.pop_front();
               if (got.sample !== want.sample) begin
                  $error("mixed_sample: expected %h, got %h", want.sample, got.sample);
                  fail_count++;
               end
               if (got.clip !== want.clip) begin
                  $error("clipped: expected %b, got %b", want.clip, got.clip);
                  fail_count++;
               end
               if (got.mask !== want.mask) begin
                  $error("active_mask: expected %h, got %h", want.mask, got.mask);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = {req_tuser, req_tdata[3:0], req_tdata[19:4], req_tdata[35:20],
                   req_tdata[52:36], req_tdata[60:53], req_tdata[72:61],
                   req_tdata[80:73]};
            if (cmd.op == OP_TICK) begin
               want = mix_voices();
               pending_mixes.push_back(row_typed ? row_result : want);
            end else begin
               apply_voice_cmd(cmd);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   initial begin
      mixer_cmd_type c;
      int            roll;

      add_checked(16'h0000, 1'b0, 16'h0000);
      add_cmd(OP_WRITE, 4'd0, 16'h0000, OUT_MAX, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_WRITE, 4'd0, 16'hffff, OUT_MIN, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_START, 4'd0, 16'h0000, 16'h0, 17'd1, 8'd0, 12'd0, 8'hff);
      add_checked(OUT_MAX, 1'b0, 16'h0001);
      add_cmd(OP_START, 4'd15, 16'h0000, 16'h0, 17'd1, 8'd0, 12'd0, UNITY_LIMIT + 8'd1);
      add_checked(OUT_MAX, 1'b1, 16'h8001);
      add_cmd(OP_START, 4'd0, 16'hffff, 16'h0, 17'd1, 8'd0, 12'd0, 8'hff);
      add_cmd(OP_START, 4'd15, 16'hffff, 16'h0, 17'd1, 8'd0, 12'd0, 8'hff);
      add_checked(OUT_MIN, 1'b1, 16'h8001);
      add_cmd(OP_RETUNE, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, UNITY_LIMIT);
      add_cmd(OP_TICK, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_STOP, 4'd15, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_TICK, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_STOP, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_RETUNE, 4'd3, 16'h0, 16'h0, 17'd0, 8'hff, 12'hfff, 8'd0);
      add_checked(16'h0000, 1'b0, 16'h0000);
      add_cmd(OP_START, 4'd5, 16'h0000, 16'h0, 17'd0, 8'd1, 12'd0, 8'd128);
      add_cmd(OP_TICK, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_TICK, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_START, 4'd9, 16'hfff0, 16'h0, 17'h10000, 8'hff, 12'hfff, 8'd200);
      add_cmd(OP_TICK, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);
      add_cmd(OP_RSVD_FIRST, 4'hf, 16'hffff, 16'hffff, 17'h1ffff, 8'hff, 12'hfff, 8'hff);
      add_cmd(OP_RSVD_LAST, 4'hf, 16'hffff, 16'hffff, 17'h1ffff, 8'hff, 12'hfff, 8'hff);
      add_cmd(OP_TICK, 4'd0, 16'h0, 16'h0, 17'd0, 8'd0, 12'd0, 8'd0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].result);

      // hold off the result side so the mixer backs up into its input
      holdoff_req = 1'b1;
      items_driven = 0;
      while (items_driven < RANDOM_ITEMS) begin
         quiet = (items_driven >= QUIET_FIRST) && (items_driven < QUIET_LAST);
         c = random_fields();
         roll = $urandom_range(99);
         if (roll < 38) begin
            c.op = OP_TICK;
         end else if (roll < 55) begin
            c.op = OP_START;
            if ($urandom_range(1)) c.addr = 16'($urandom_range(255));
            case ($urandom_range(19))
               0, 1: c.len = 17'd0;
               2: c.len = 17'h10000;
               3: ;
               default: c.len = 17'($urandom_range(64, 1));
            endcase
            shape_tuning(c);
         end else if (roll < 62) begin
            c.op = OP_STOP;
         end else if (roll < 72) begin
            c.op = OP_RETUNE;
            shape_tuning(c);
         end else if (roll < 92) begin
            c.op = OP_WRITE;
            if ($urandom_range(9) < 6) c.addr = 16'($urandom_range(511));
            c.value = pick_sample();
         end else begin
            c.op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
         end
         issue(c, 1'b0, '0);
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_mixes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
